// ----- sv/scpa_pkg.sv -----
// ----------------------------------------------------------------------------
// scpa_pkg: shared types and constants of the size class pool allocator
// Class geometry, status codes, sequencer states and the statistics command.
// ----------------------------------------------------------------------------
package scpa_pkg;

    localparam int NUM_CLASSES          = 12;
    localparam int BLOCKS_PER_CLASS     = 1024;
    localparam int SMALLEST_CLASS_BYTES = 32;

    localparam int CLS_W   = 4;
    localparam int IDX_W   = $clog2(BLOCKS_PER_CLASS);
    localparam int ADDR_W  = CLS_W + IDX_W;
    localparam int SLOTS   = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int MAX_CAP = SMALLEST_CLASS_BYTES << (NUM_CLASSES - 1);
    localparam int BYTES_W = $clog2(MAX_CAP + 1);
    localparam int DEPTH_W = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int CNT_W   = 64;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_MISS   = 2'd1,
        STATUS_ZERO   = 2'd2,
        STATUS_REJECT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_SEARCH,
        SEQ_POP,
        SEQ_MARK,
        SEQ_FCHK,
        SEQ_GIVEN,
        SEQ_COUNT,
        SEQ_HITS,
        SEQ_PEAK,
        SEQ_MISS,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [3:0] {
        STAT_NONE,
        STAT_ADD_USAGE,
        STAT_SUB_USAGE,
        STAT_ADD_GIVEN,
        STAT_ADD_RETURNED,
        STAT_INC_GRANTS,
        STAT_INC_FREES,
        STAT_INC_HITS,
        STAT_INC_MISS,
        STAT_PEAK
    } stat_op_t;

    typedef struct packed {
        stat_op_t             op;
        logic [BYTES_W-1:0]   operand;
    } stat_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] usage;
        logic [CNT_W-1:0] peak;
        logic [CNT_W-1:0] given;
        logic [CNT_W-1:0] returned;
        logic [CNT_W-1:0] grants;
        logic [CNT_W-1:0] frees;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } stat_vals_t;

    function automatic logic [31:0] class_capacity(input logic [CLS_W-1:0] cls);
        logic [31:0] cap;
        cap = 32'(SMALLEST_CLASS_BYTES) << cls;
        return cap;
    endfunction

endpackage

// ----- sv/scpa_stats.sv -----
// ----------------------------------------------------------------------------
// scpa_stats: statistics counters with one shared 64-bit adder
// Each cycle at most one counter is updated, chosen by the sequencer command.
// ----------------------------------------------------------------------------
module scpa_stats (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  scpa_pkg::stat_cmd_t    cmd,
    output scpa_pkg::stat_vals_t   vals
);
    import scpa_pkg::*;

    stat_vals_t       vals_reg;
    stat_vals_t       vals_next;
    logic [CNT_W-1:0] add_a;
    logic [CNT_W-1:0] add_b;
    logic             add_sub;
    logic [CNT_W-1:0] add_sum;

    always_comb begin
        add_a   = '0;
        add_b   = {{(CNT_W-BYTES_W){1'b0}}, cmd.operand};
        add_sub = 1'b0;
        unique case (cmd.op)
            STAT_ADD_USAGE:    add_a = vals_reg.usage;
            STAT_SUB_USAGE: begin
                add_a   = vals_reg.usage;
                add_sub = 1'b1;
            end
            STAT_ADD_GIVEN:    add_a = vals_reg.given;
            STAT_ADD_RETURNED: add_a = vals_reg.returned;
            STAT_INC_GRANTS: begin
                add_a = vals_reg.grants;
                add_b = CNT_W'(1);
            end
            STAT_INC_FREES: begin
                add_a = vals_reg.frees;
                add_b = CNT_W'(1);
            end
            STAT_INC_HITS: begin
                add_a = vals_reg.hits;
                add_b = CNT_W'(1);
            end
            STAT_INC_MISS: begin
                add_a = vals_reg.misses;
                add_b = CNT_W'(1);
            end
            default: ;
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(CNT_W-1){1'b0}}, add_sub};

        vals_next = vals_reg;
        unique case (cmd.op)
            STAT_ADD_USAGE, STAT_SUB_USAGE: vals_next.usage = add_sum;
            STAT_ADD_GIVEN:    vals_next.given    = add_sum;
            STAT_ADD_RETURNED: vals_next.returned = add_sum;
            STAT_INC_GRANTS:   vals_next.grants   = add_sum;
            STAT_INC_FREES:    vals_next.frees    = add_sum;
            STAT_INC_HITS:     vals_next.hits     = add_sum;
            STAT_INC_MISS:     vals_next.misses   = add_sum;
            STAT_PEAK: begin
                if (vals_reg.usage > vals_reg.peak) begin
                    vals_next.peak = vals_reg.usage;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vals_reg <= '0;
        end else begin
            vals_reg <= vals_next;
        end
    end

    assign vals = vals_reg;

endmodule

// ----- sv/size_class_pool_allocator_top.sv -----
// ----------------------------------------------------------------------------
// size_class_pool_allocator_top: segregated size class pool allocator
// Allocates and frees fixed blocks in doubling size classes and keeps usage
// statistics.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   func, req_size, free_class, free_index
//  m_        out        m_valid / m_ready   status, grant, eight 64-bit statistics
//
//  After reset the live map is swept, one entry a cycle, over all 12288 entries;
//  no request is accepted until the sweep ends.
//  A free steps FCHK, GIVEN, COUNT, DONE; an allocate SEARCH per class tried,
//  POP on reuse, MARK, GIVEN, COUNT, HITS, PEAK, DONE on the one shared adder.
//  One request is in flight at a time; a result held by m_ready stalls the next.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_func,
    input  logic [31:0]  s_req_size,
    input  logic [3:0]   s_free_class,
    input  logic [9:0]   s_free_index,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_status,
    output logic [3:0]   m_grant_class,
    output logic [9:0]   m_grant_index,
    output logic [63:0]  m_usage_now,
    output logic [63:0]  m_usage_peak,
    output logic [63:0]  m_bytes_given,
    output logic [63:0]  m_bytes_returned,
    output logic [63:0]  m_grants_made,
    output logic [63:0]  m_frees_done,
    output logic [63:0]  m_hit_total,
    output logic [63:0]  m_miss_total
);
    import scpa_pkg::*;

    seq_state_t         state_reg, state_next;
    logic               func_reg, func_next;
    logic [CLS_W-1:0]   cls_reg, cls_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BYTES_W-1:0] opnd_reg, opnd_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [DEPTH_W-1:0] depth_reg [NUM_CLASSES];
    logic [DEPTH_W-1:0] depth_next [NUM_CLASSES];
    logic [DEPTH_W-1:0] fresh_reg [NUM_CLASSES];
    logic [DEPTH_W-1:0] fresh_next [NUM_CLASSES];

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [CLS_W-1:0]   out_cls_reg, out_cls_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    stat_vals_t         out_vals_reg, out_vals_next;

    // Block memory: live flag on top, requested bytes below.
    logic [BYTES_W:0]   blk_mem [SLOTS];
    logic [BYTES_W:0]   blk_rdata_reg;
    logic               blk_we;
    logic [ADDR_W-1:0]  blk_waddr;
    logic [BYTES_W:0]   blk_wdata;
    logic [ADDR_W-1:0]  blk_raddr;

    logic [IDX_W-1:0]   stk_mem [SLOTS];
    logic [IDX_W-1:0]   stk_rdata_reg;
    logic               stk_we;
    logic [ADDR_W-1:0]  stk_waddr;
    logic [IDX_W-1:0]   stk_wdata;
    logic [ADDR_W-1:0]  stk_raddr;

    stat_cmd_t          stat_cmd;
    stat_vals_t         stat_vals;

    logic               fit_found;
    logic [CLS_W-1:0]   fit_cls;
    logic [DEPTH_W-1:0] cur_depth;
    logic [DEPTH_W-1:0] cur_fresh;
    logic [DEPTH_W-1:0] depth_dec;

    scpa_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stat_cmd),
        .vals    (stat_vals)
    );

    // Smallest class whose capacity covers the request.
    always_comb begin
        fit_found = 1'b0;
        fit_cls   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (s_req_size <= class_capacity(CLS_W'(c))) begin
                fit_found = 1'b1;
                fit_cls   = CLS_W'(c);
            end
        end
    end

    assign cur_depth = depth_reg[cls_reg];
    assign cur_fresh = fresh_reg[cls_reg];
    assign depth_dec = cur_depth - DEPTH_W'(1);

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        cls_next        = cls_reg;
        idx_next        = idx_reg;
        opnd_next       = opnd_reg;
        status_next     = status_reg;
        clr_next        = clr_reg;
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_cls_next    = out_cls_reg;
        out_idx_next    = out_idx_reg;
        out_vals_next   = out_vals_reg;
        s_ready         = 1'b0;
        blk_we          = 1'b0;
        blk_waddr       = {cls_reg, idx_reg};
        blk_wdata       = '0;
        blk_raddr       = {s_free_class, s_free_index};
        stk_we          = 1'b0;
        stk_waddr       = {cls_reg, cur_depth[IDX_W-1:0]};
        stk_wdata       = idx_reg;
        stk_raddr       = {cls_reg, depth_dec[IDX_W-1:0]};
        stat_cmd.op      = STAT_NONE;
        stat_cmd.operand = opnd_reg;

        unique case (state_reg)
            SEQ_CLEAR: begin
                blk_we    = 1'b1;
                blk_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(SLOTS - 1)) begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next = s_func;
                    idx_next  = s_free_index;
                    if (!s_func) begin
                        opnd_next = s_req_size[BYTES_W-1:0];
                        if (s_req_size == 32'd0) begin
                            status_next = STATUS_ZERO;
                            state_next  = SEQ_DONE;
                        end else if (!fit_found) begin
                            state_next = SEQ_MISS;
                        end else begin
                            cls_next   = fit_cls;
                            state_next = SEQ_SEARCH;
                        end
                    end else begin
                        cls_next = s_free_class;
                        if (s_free_class >= CLS_W'(NUM_CLASSES)) begin
                            status_next = STATUS_REJECT;
                            state_next  = SEQ_DONE;
                        end else begin
                            state_next = SEQ_FCHK;
                        end
                    end
                end
            end
            SEQ_SEARCH: begin
                if (cur_depth != '0) begin
                    depth_next[cls_reg] = depth_dec;
                    state_next          = SEQ_POP;
                end else if (cur_fresh < DEPTH_W'(BLOCKS_PER_CLASS)) begin
                    idx_next            = cur_fresh[IDX_W-1:0];
                    fresh_next[cls_reg] = cur_fresh + DEPTH_W'(1);
                    state_next          = SEQ_MARK;
                end else if (cls_reg == CLS_W'(NUM_CLASSES - 1)) begin
                    state_next = SEQ_MISS;
                end else begin
                    cls_next = cls_reg + CLS_W'(1);
                end
            end
            SEQ_POP: begin
                idx_next   = stk_rdata_reg;
                state_next = SEQ_MARK;
            end
            SEQ_MARK: begin
                blk_we      = 1'b1;
                blk_wdata   = {1'b1, opnd_reg};
                stat_cmd.op = STAT_ADD_USAGE;
                status_next = STATUS_OK;
                state_next  = SEQ_GIVEN;
            end
            SEQ_FCHK: begin
                if (!blk_rdata_reg[BYTES_W]) begin
                    status_next = STATUS_REJECT;
                    state_next  = SEQ_DONE;
                end else begin
                    blk_we = 1'b1;
                    if (cur_depth < DEPTH_W'(BLOCKS_PER_CLASS)) begin
                        stk_we              = 1'b1;
                        depth_next[cls_reg] = cur_depth + DEPTH_W'(1);
                    end
                    opnd_next        = blk_rdata_reg[BYTES_W-1:0];
                    stat_cmd.op      = STAT_SUB_USAGE;
                    stat_cmd.operand = blk_rdata_reg[BYTES_W-1:0];
                    status_next      = STATUS_OK;
                    state_next       = SEQ_GIVEN;
                end
            end
            SEQ_GIVEN: begin
                stat_cmd.op = func_reg ? STAT_ADD_RETURNED : STAT_ADD_GIVEN;
                state_next  = SEQ_COUNT;
            end
            SEQ_COUNT: begin
                if (func_reg) begin
                    stat_cmd.op = STAT_INC_FREES;
                    state_next  = SEQ_DONE;
                end else begin
                    stat_cmd.op = STAT_INC_GRANTS;
                    state_next  = SEQ_HITS;
                end
            end
            SEQ_HITS: begin
                stat_cmd.op = STAT_INC_HITS;
                state_next  = SEQ_PEAK;
            end
            SEQ_PEAK: begin
                stat_cmd.op = STAT_PEAK;
                state_next  = SEQ_DONE;
            end
            SEQ_MISS: begin
                stat_cmd.op = STAT_INC_MISS;
                status_next = STATUS_MISS;
                state_next  = SEQ_DONE;
            end
            SEQ_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_vals_next   = stat_vals;
                    if (status_reg == STATUS_OK && !func_reg) begin
                        out_cls_next = cls_reg;
                        out_idx_next = idx_reg;
                    end else begin
                        out_cls_next = '0;
                        out_idx_next = '0;
                    end
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                depth_reg[c] <= '0;
                fresh_reg[c] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        cls_reg        <= cls_next;
        idx_reg        <= idx_next;
        opnd_reg       <= opnd_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_cls_reg    <= out_cls_next;
        out_idx_reg    <= out_idx_next;
        out_vals_reg   <= out_vals_next;
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rdata_reg <= blk_mem[blk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_grant_class    = out_cls_reg;
    assign m_grant_index    = out_idx_reg;
    assign m_usage_now      = out_vals_reg.usage;
    assign m_usage_peak     = out_vals_reg.peak;
    assign m_bytes_given    = out_vals_reg.given;
    assign m_bytes_returned = out_vals_reg.returned;
    assign m_grants_made    = out_vals_reg.grants;
    assign m_frees_done     = out_vals_reg.frees;
    assign m_hit_total      = out_vals_reg.hits;
    assign m_miss_total     = out_vals_reg.misses;

endmodule

// ----- verif/size_class_pool_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// Size class pool allocator testbench
// Drives allocate and free requests through the valid/ready input channel,
// predicts every result with a behavioral copy of the allocator state, and
// checks each result transfer field by field under random idling.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scpa_pkg::*;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;
    localparam int   CYCLE_LIMIT = 1500000;

    typedef struct {
        status_t     status;
        logic [3:0]  gclass;
        logic [9:0]  gindex;
        logic [63:0] usage, peak, given, returned, grants, frees, hits, misses;
    } alloc_result_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class pool_scoreboard;
        logic [9:0]  freed_stack [NUM_CLASSES][BLOCKS_PER_CLASS];
        int          freed_depth [NUM_CLASSES];
        int          fresh_next [NUM_CLASSES];
        bit          live [NUM_CLASSES][BLOCKS_PER_CLASS];
        logic [31:0] bytes_of [NUM_CLASSES][BLOCKS_PER_CLASS];
        logic [63:0] usage, peak, given, returned, grants, frees, hits, misses;
        alloc_result_t pending[$];

        function new();
            foreach (freed_depth[c]) begin
                freed_depth[c] = 0;
                fresh_next[c] = 0;
                foreach (live[c][i]) live[c][i] = 0;
            end
            {usage, peak, given, returned, grants, frees, hits, misses} = '0;
        endfunction

        function void note_request(input logic func, input logic [31:0] size,
                                   input logic [3:0] fcls, input logic [9:0] fidx);
            alloc_result_t r;
            int c;
            int idx;
            bit done;
            r.gclass = '0;
            r.gindex = '0;
            if (func == FUNC_ALLOC) begin
                if (size == 0) begin
                    r.status = STATUS_ZERO;
                end else begin
                    done = 0;
                    for (c = 0; c < NUM_CLASSES && !done; c++) begin
                        if (64'(size) > (64'(SMALLEST_CLASS_BYTES) << c)) continue;
                        if (freed_depth[c] > 0) begin
                            freed_depth[c]--;
                            idx = freed_stack[c][freed_depth[c]];
                        end else if (fresh_next[c] < BLOCKS_PER_CLASS) begin
                            idx = fresh_next[c];
                            fresh_next[c]++;
                        end else begin
                            continue;
                        end
                        live[c][idx] = 1;
                        bytes_of[c][idx] = size;
                        hits++; given += size; usage += size; grants++;
                        if (usage > peak) peak = usage;
                        r.gclass = 4'(c);
                        r.gindex = 10'(idx);
                        done = 1;
                    end
                    if (done) r.status = STATUS_OK;
                    else begin
                        misses++;
                        r.status = STATUS_MISS;
                    end
                end
            end else if (fcls >= NUM_CLASSES || !live[fcls][fidx]) begin
                r.status = STATUS_REJECT;
            end else begin
                live[fcls][fidx] = 0;
                if (freed_depth[fcls] < BLOCKS_PER_CLASS) begin
                    freed_stack[fcls][freed_depth[fcls]] = fidx;
                    freed_depth[fcls]++;
                end
                returned += bytes_of[fcls][fidx];
                usage -= bytes_of[fcls][fidx];
                frees++;
                r.status = STATUS_OK;
            end
            {r.usage, r.peak, r.given, r.returned} = {usage, peak, given, returned};
            {r.grants, r.frees, r.hits, r.misses} = {grants, frees, hits, misses};
            pending.push_back(r);
        endfunction

        task check_result(input alloc_result_t got);
            alloc_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 64'(got.status), 0);
                return;
            end
            w = pending.pop_front();
            if (got.status != w.status) report_mismatch("status", got.status, w.status);
            if (got.gclass != w.gclass) report_mismatch("grant_class", got.gclass, w.gclass);
            if (got.gindex != w.gindex) report_mismatch("grant_index", got.gindex, w.gindex);
            if (got.usage != w.usage) report_mismatch("usage_now", got.usage, w.usage);
            if (got.peak != w.peak) report_mismatch("usage_peak", got.peak, w.peak);
            if (got.given != w.given) report_mismatch("bytes_given", got.given, w.given);
            if (got.returned != w.returned)
                report_mismatch("bytes_returned", got.returned, w.returned);
            if (got.grants != w.grants) report_mismatch("grants_made", got.grants, w.grants);
            if (got.frees != w.frees) report_mismatch("frees_done", got.frees, w.frees);
            if (got.hits != w.hits) report_mismatch("hit_total", got.hits, w.hits);
            if (got.misses != w.misses) report_mismatch("miss_total", got.misses, w.misses);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_func = 0;
    logic [31:0] s_req_size = '0;
    logic [3:0]  s_free_class = '0;
    logic [9:0]  s_free_index = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [3:0]  m_grant_class;
    logic [9:0]  m_grant_index;
    logic [63:0] m_usage_now, m_usage_peak, m_bytes_given, m_bytes_returned;
    logic [63:0] m_grants_made, m_frees_done, m_hit_total, m_miss_total;

    size_class_pool_allocator_top u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    pool_scoreboard board = new();
    int send_idle_pct = 29;
    int recv_idle_pct = 52;
    int cycles = 0;
    // Live blocks as seen by the stimulus, so frees can target real blocks.
    logic [13:0] held[$];

    always @(posedge aclk) begin
        alloc_result_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            got.status = status_t'(m_status);
            got.gclass = m_grant_class;
            got.gindex = m_grant_index;
            {got.usage, got.peak, got.given, got.returned} =
                {m_usage_now, m_usage_peak, m_bytes_given, m_bytes_returned};
            {got.grants, got.frees, got.hits, got.misses} =
                {m_grants_made, m_frees_done, m_hit_total, m_miss_total};
            board.check_result(got);
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high after a transfer only when the next item follows at once;
    // an idle cycle or a drain lowers it.
    task automatic send_item(input logic func, input logic [31:0] size,
                             input logic [3:0] fcls, input logic [9:0] fidx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= func;
        s_req_size <= size;
        s_free_class <= fcls;
        s_free_index <= fidx;
        do @(posedge aclk); while (!s_ready);
        board.note_request(func, size, fcls, fidx);
        // Track grants from the prediction to pick later frees.
        if (func == FUNC_ALLOC && board.pending[$].status == STATUS_OK)
            held.push_back({board.pending[$].gclass, board.pending[$].gindex});
    endtask

    task automatic do_alloc(input logic [31:0] size);
        send_item(FUNC_ALLOC, size, 4'($urandom), 10'($urandom));
    endtask

    task automatic do_free_held(input bit newest);
        int k;
        logic [13:0] b;
        if (held.size() == 0) return;
        k = newest ? held.size() - 1 : $urandom_range(held.size() - 1);
        b = held[k];
        held.delete(k);
        send_item(FUNC_FREE, $urandom, b[13:10], b[9:0]);
    endtask

    task automatic random_item();
        int pick;
        int cls;
        pick = $urandom_range(99);
        cls = $urandom_range(NUM_CLASSES - 1);
        if (pick < 45)
            do_alloc($urandom_range(SMALLEST_CLASS_BYTES << cls, 1));
        else if (pick < 80)
            do_free_held(pick < 50);
        else if (pick < 85)
            do_alloc($urandom);
        else if (pick < 88)
            do_alloc(0);
        else
            send_item(FUNC_FREE, $urandom, 4'($urandom), 10'($urandom));
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int i;
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // Directed: zero size, smallest and largest sizes, oversize, bad frees.
        do_alloc(0);
        do_alloc(1);
        do_alloc(32);
        do_alloc(33);
        do_alloc(65536);
        do_alloc(65537);
        do_alloc(32'hFFFF_FFFF);
        send_item(FUNC_FREE, 0, 4'd15, 10'd0);
        send_item(FUNC_FREE, 32'hFFFF_FFFF, 4'd12, 10'd1023);
        send_item(FUNC_FREE, 0, 4'd0, 10'd1023);
        do_free_held(1);
        do_free_held(0);
        do_free_held(1);
        send_item(FUNC_FREE, 0, 4'd11, 10'd0);   // double free
        do_alloc(20);                             // reuses the freed block
        do_alloc(32'h0000_FFFF);
        drain();

        for (i = 0; i < 400; i++) begin
            if (i == 130) begin
                send_idle_pct = 52;
                recv_idle_pct = 29;
            end
            if (i == 200) drain();
            if (i == 270) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_item();
        end
        drain();

        if (errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
